[hw/rtl/vvf_pkg.sv]
// Shared types, constants and arithmetic helpers of the vertex viewport and fog stage.
package vvf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int QBITS      = 32;
    localparam int FOG_QBITS  = 8;
    localparam int SAT_SHIFT  = 31 - FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [31:0] FX_ONE      = 32'sd1 <<< FRAC_BITS;
    localparam logic [16:0]        UV_OUT_ONE  = 17'h10000;
    localparam logic [31:0]        POS_SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]        NEG_SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        FOG_NONE = 2'd0,
        FOG_MULT = 2'd1,
        FOG_HAZE = 2'd2
    } fog_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_BASE      = 3'd2,
        REG_FOG_MODE  = 3'd3,
        REG_FOG_START = 3'd4,
        REG_FOG_END   = 3'd5,
        REG_FOG_COLOR = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        PH_MAIN = 1'b0,
        PH_TWIN = 1'b1
    } out_phase_t;

    typedef struct packed {
        logic [13:0]        width;
        logic [13:0]        height;
        logic [31:0]        base_color;
        logic [1:0]         fog_mode;
        logic signed [31:0] fog_start;
        logic signed [31:0] fog_end;
        logic [23:0]        fog_color;
    } cfg_t;

    // One vertex as it moves down the pipeline; later stages fill later fields.
    typedef struct packed {
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic [32:0]        den;
        logic               winv;
        logic signed [32:0] span;
        logic signed [32:0] numer;
        logic [32:0]        fd;
        logic [32:0]        fn;
        logic [16:0]        u;
        logic [16:0]        v;
        logic               haze;
        logic               mult;
        logic [1:0][47:0]   pnum;
        logic [1:0]         pneg;
        logic [1:0][47:0]   pmag;
        logic [1:0]         pov;
        logic [1:0][33:0]   prem;
        logic [1:0][31:0]   plow;
        logic [1:0][31:0]   pq;
        logic [2:0][7:0]    fc;
        logic [2:0][32:0]   fnum;
        logic [2:0][40:0]   fprod;
        logic [2:0][33:0]   frem;
        logic [2:0][7:0]    flow;
        logic [2:0][7:0]    fq;
        logic [33:0]        fden;
    } item_t;

    // One restoring division step: {quotient bit, new remainder}.
    function automatic logic [34:0] div_step(input logic [33:0] rem,
                                             input logic [33:0] dvs,
                                             input logic        b);
        logic [34:0] sh;
        logic [34:0] diff;
        sh   = {rem, b};
        diff = sh - {1'b0, dvs};
        if (sh >= {1'b0, dvs})
            return {1'b1, diff[33:0]};
        else
            return {1'b0, sh[33:0]};
    endfunction

endpackage

[hw/rtl/vertex_viewport_fog_stage_top.sv]
// Top level of the vertex viewport and linear fog stage.
//
// Each input transaction is one clip-space vertex; the block divides x and y by w,
// maps them to canvas pixels (y flipped), clamps u and v to [0,1], attaches the
// base RGBA color and applies linear fog. Unless the output stalls or a haze twin
// is owed, a vertex enters every clock and passes five setup stages, a 32-stage
// restoring divider that retires one quotient bit per stage for both position
// lanes (the fog lanes use the first eight of those stages), a rounding stage and
// the output register. In haze mode every vertex produces two output transactions,
// the main vertex with last low and then the fog twin, so input is held while the
// main one is sent. The output register holds a waiting result while the pipeline
// behind it holds as well; nothing is dropped or repeated under stall. There
// is no memory and no clearing pass after reset. Configuration registers are read
// directly by the front and back ends, so write them only while the block is idle.
module vertex_viewport_fog_stage_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vvf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vvf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                clip_x,
    input  logic signed [31:0]                clip_y,
    input  logic signed [31:0]                clip_w,
    input  logic signed [31:0]                tex_u_in,
    input  logic signed [31:0]                tex_v_in,
    input  logic signed [31:0]                eye_depth,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                screen_x,
    output logic signed [31:0]                screen_y,
    output logic [16:0]                       tex_u_out,
    output logic [16:0]                       tex_v_out,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [7:0]                        alpha,
    output logic                              is_haze,
    output logic                              last,
    output logic                              w_invalid
);
    import vvf_pkg::*;

    cfg_t  cfg_reg;
    logic  en;
    logic  fr_valid, dv_valid;
    item_t fr_item, dv_item;

    // Register file; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width      <= 14'd640;
            cfg_reg.height     <= 14'd480;
            cfg_reg.base_color <= 32'hFFFF_FFFF;
            cfg_reg.fog_mode   <= FOG_NONE;
            cfg_reg.fog_start  <= '0;
            cfg_reg.fog_end    <= '0;
            cfg_reg.fog_color  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:     cfg_reg.width      <= cfg_data[13:0];
                REG_HEIGHT:    cfg_reg.height     <= cfg_data[13:0];
                REG_BASE:      cfg_reg.base_color <= cfg_data;
                REG_FOG_MODE:  cfg_reg.fog_mode   <= cfg_data[1:0];
                REG_FOG_START: cfg_reg.fog_start  <= $signed(cfg_data);
                REG_FOG_END:   cfg_reg.fog_end    <= $signed(cfg_data);
                REG_FOG_COLOR: cfg_reg.fog_color  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together; hold input whenever it cannot.
    assign in_stall = !en;

    vvf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_w    (clip_w),
        .tex_u_in  (tex_u_in),
        .tex_v_in  (tex_v_in),
        .eye_depth (eye_depth),
        .cfg       (cfg_reg),
        .out_valid (fr_valid),
        .out_item  (fr_item)
    );

    vvf_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    vvf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .cfg       (cfg_reg),
        .out_stall (out_stall),
        .en        (en),
        .out_valid (out_valid),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .tex_u_out (tex_u_out),
        .tex_v_out (tex_v_out),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .is_haze   (is_haze),
        .last      (last),
        .w_invalid (w_invalid)
    );

`ifndef SYNTHESIS
    a_twin_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && is_haze)
        else $error("haze twin missing after main vertex");

    a_twin_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_haze |-> last)
        else $error("haze twin without last");

    a_winv_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_invalid |-> screen_x == 32'sh7FFF_FFFF && screen_y == 32'sh7FFF_FFFF)
        else $error("position not saturated for non-positive w");

    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tex_u_out <= UV_OUT_ONE && tex_v_out <= UV_OUT_ONE)
        else $error("texture coordinate above one");
`endif

endmodule

[hw/rtl/vvf_front.sv]
// Front stages: sums, viewport products, fog factor and divider setup.
module vvf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] clip_x,
    input  logic signed [31:0] clip_y,
    input  logic signed [31:0] clip_w,
    input  logic signed [31:0] tex_u_in,
    input  logic signed [31:0] tex_v_in,
    input  logic signed [31:0] eye_depth,
    input  vvf_pkg::cfg_t      cfg,
    output logic               out_valid,
    output vvf_pkg::item_t     out_item
);
    import vvf_pkg::*;

    logic [4:0] vld_reg;
    item_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    item_t s1_next, s2_next, s3_next, s4_next, s5_next;

    function automatic logic [16:0] clamp_uv(input logic signed [31:0] raw);
        logic [47:0] wide;
        wide = 48'(unsigned'(raw)) << 16;
        wide = wide >> FRAC_BITS;
        if (raw <= 32'sd0)
            return '0;
        else if (raw >= FX_ONE)
            return UV_OUT_ONE;
        else
            return wide[16:0];
    endfunction

    // Sums and differences straight off the input.
    always_comb
    begin
        s1_next       = '0;
        s1_next.xs    = $signed({clip_x[31], clip_x}) + $signed({clip_w[31], clip_w});
        s1_next.ys    = $signed({clip_w[31], clip_w}) - $signed({clip_y[31], clip_y});
        s1_next.den   = {clip_w, 1'b0};
        s1_next.winv  = clip_w[31] || (clip_w == 32'sd0);
        s1_next.span  = $signed({cfg.fog_end[31], cfg.fog_end})
                      - $signed({cfg.fog_start[31], cfg.fog_start});
        s1_next.numer = $signed({cfg.fog_end[31], cfg.fog_end})
                      - $signed({eye_depth[31], eye_depth});
        s1_next.u     = clamp_uv(tex_u_in);
        s1_next.v     = clamp_uv(tex_v_in);
        s1_next.haze  = (cfg.fog_mode == FOG_HAZE);
        s1_next.mult  = (cfg.fog_mode == FOG_MULT);
    end

    // Viewport products and the clamped fog fraction.
    always_comb
    begin : stage2_logic
        logic signed [32:0] spn;
        s2_next = s1_reg;
        s2_next.pnum[0] = 48'($signed({1'b0, cfg.width}))  * 48'(s1_reg.xs);
        s2_next.pnum[1] = 48'($signed({1'b0, cfg.height})) * 48'(s1_reg.ys);
        spn = (s1_reg.span < 33'sd1) ? 33'sd1 : s1_reg.span;
        s2_next.fd = unsigned'(spn);
        if (s1_reg.numer <= 33'sd0)
            s2_next.fn = '0;
        else if (s1_reg.numer >= spn)
            s2_next.fn = unsigned'(spn);
        else
            s2_next.fn = unsigned'(s1_reg.numer);
    end

    // Magnitudes and fog lane operands.
    always_comb
    begin
        s3_next = s2_reg;
        for (int l = 0; l < 2; l++)
        begin
            s3_next.pneg[l] = s2_reg.pnum[l][47];
            s3_next.pmag[l] = s2_reg.pnum[l][47] ? (~s2_reg.pnum[l] + 48'd1) : s2_reg.pnum[l];
        end
        s3_next.fc[0]   = s2_reg.haze ? 8'hFF : cfg.base_color[31:24];
        s3_next.fc[1]   = cfg.base_color[23:16];
        s3_next.fc[2]   = cfg.base_color[15:8];
        s3_next.fnum[0] = s2_reg.haze ? (s2_reg.fd - s2_reg.fn) : s2_reg.fn;
        s3_next.fnum[1] = s2_reg.fn;
        s3_next.fnum[2] = s2_reg.fn;
    end

    // Overflow check, divider seed, and fog lane products.
    always_comb
    begin : stage4_logic
        logic [79:0] dvd;
        s4_next = s3_reg;
        for (int l = 0; l < 2; l++)
        begin
            dvd = 80'(s3_reg.pmag[l]) << (FRAC_BITS + 1);
            s4_next.pov[l]  = s3_reg.pmag[l] >= (48'(s3_reg.den) << SAT_SHIFT);
            s4_next.prem[l] = dvd[65:32];
            s4_next.plow[l] = dvd[31:0];
        end
        for (int l = 0; l < 3; l++)
            s4_next.fprod[l] = 41'(s3_reg.fc[l]) * 41'(s3_reg.fnum[l]);
    end

    // Fog dividend with the half-up rounding term folded in.
    always_comb
    begin : stage5_logic
        logic [41:0] fdv;
        s5_next = s4_reg;
        s5_next.fden = {s4_reg.fd, 1'b0};
        for (int l = 0; l < 3; l++)
        begin
            fdv = 42'({s4_reg.fprod[l], 1'b0}) + 42'(s4_reg.fd);
            s5_next.frem[l] = fdv[FOG_QBITS +: 34];
            s5_next.flow[l] = fdv[FOG_QBITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_item  = s5_reg;

endmodule

[hw/rtl/vvf_div_pipe.sv]
// Restoring divider: one quotient bit per stage, fog lanes only early.
module vvf_div_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  vvf_pkg::item_t in_item,
    output logic           out_valid,
    output vvf_pkg::item_t out_item
);
    import vvf_pkg::*;

    logic [QBITS-1:0] vld_reg;
    item_t stage_reg  [QBITS];
    item_t stage_next [QBITS];
    item_t chain      [QBITS+1];

    function automatic item_t div_stage(input item_t it, input int k);
        item_t       r;
        logic [34:0] sp;
        r = it;
        for (int l = 0; l < 2; l++)
        begin
            sp = div_step(it.prem[l], {1'b0, it.den}, it.plow[l][31]);
            r.prem[l] = sp[33:0];
            r.plow[l] = {it.plow[l][30:0], 1'b0};
            r.pq[l]   = {it.pq[l][30:0], sp[34]};
        end
        if (k < FOG_QBITS)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sp = div_step(it.frem[l], it.fden, it.flow[l][FOG_QBITS-1]);
                r.frem[l] = sp[33:0];
                r.flow[l] = {it.flow[l][FOG_QBITS-2:0], 1'b0};
                r.fq[l]   = {it.fq[l][6:0], sp[34]};
            end
        end
        return r;
    endfunction

    always_comb
    begin
        chain[0] = in_item;
        for (int k = 0; k < QBITS; k++)
            chain[k+1] = stage_reg[k];
        for (int k = 0; k < QBITS; k++)
            stage_next[k] = div_stage(chain[k], k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QBITS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QBITS; k++)
                stage_reg[k] <= stage_next[k];
        end
    end

    assign out_valid = vld_reg[QBITS-1];
    assign out_item  = stage_reg[QBITS-1];

endmodule

[hw/rtl/vvf_out.sv]
// Back end: rounding, saturation, color select, and the output register with haze twin.
module vvf_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vvf_pkg::item_t     in_item,
    input  vvf_pkg::cfg_t      cfg,
    input  logic               out_stall,
    output logic               en,
    output logic               out_valid,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic [16:0]        tex_u_out,
    output logic [16:0]        tex_v_out,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha,
    output logic               is_haze,
    output logic               last,
    output logic               w_invalid
);
    import vvf_pkg::*;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [16:0] u;
        logic [16:0] v;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [7:0]  fog_a;
        logic        winv;
        logic        haze;
    } vtx_t;

    logic       f1_vld_reg;
    item_t      f1_reg, f1_next;
    logic       o_vld_reg;
    vtx_t       o_reg, o_next;
    out_phase_t phase_reg, phase_next;
    logic       twin_pending;

    function automatic logic [31:0] sat_pos(input logic [31:0] val, input logic neg,
                                            input logic ov, input logic winv);
        if (winv)
            return POS_SAT_MAX;
        else if (!neg)
            return (ov || val[31]) ? POS_SAT_MAX : val;
        else
            return ov ? NEG_SAT_MIN : (32'd0 - val);
    endfunction

    // Half away from zero: drop the extra quotient bit after adding one.
    always_comb
    begin : round_logic
        logic [32:0] tmp;
        f1_next = in_item;
        for (int l = 0; l < 2; l++)
        begin
            tmp = {1'b0, in_item.pq[l]} + 33'd1;
            f1_next.pq[l] = tmp[32:1];
        end
    end

    always_comb
    begin
        o_next.sx    = sat_pos(f1_reg.pq[0], f1_reg.pneg[0], f1_reg.pov[0], f1_reg.winv);
        o_next.sy    = sat_pos(f1_reg.pq[1], f1_reg.pneg[1], f1_reg.pov[1], f1_reg.winv);
        o_next.u     = f1_reg.u;
        o_next.v     = f1_reg.v;
        o_next.r     = f1_reg.mult ? f1_reg.fq[0] : cfg.base_color[31:24];
        o_next.g     = f1_reg.mult ? f1_reg.fq[1] : cfg.base_color[23:16];
        o_next.b     = f1_reg.mult ? f1_reg.fq[2] : cfg.base_color[15:8];
        o_next.a     = cfg.base_color[7:0];
        o_next.fog_a = f1_reg.fq[0];
        o_next.winv  = f1_reg.winv;
        o_next.haze  = f1_reg.haze;
    end

    // Hold the pipeline while the twin of a haze vertex is still owed.
    assign twin_pending = o_reg.haze && (phase_reg == PH_MAIN);
    assign en           = !o_vld_reg || (!out_stall && !twin_pending);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MAIN:
            begin
                if (o_vld_reg && !out_stall && o_reg.haze)
                    phase_next = PH_TWIN;
            end
            PH_TWIN:
            begin
                if (!out_stall)
                    phase_next = PH_MAIN;
            end
            default: phase_next = PH_MAIN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            phase_reg  <= PH_MAIN;
        end
        else
        begin
            phase_reg <= phase_next;
            if (en)
            begin
                f1_vld_reg <= in_valid;
                o_vld_reg  <= f1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= f1_next;
            o_reg  <= o_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign screen_x  = $signed(o_reg.sx);
    assign screen_y  = $signed(o_reg.sy);
    assign tex_u_out = (phase_reg == PH_TWIN) ? 17'd0 : o_reg.u;
    assign tex_v_out = (phase_reg == PH_TWIN) ? 17'd0 : o_reg.v;
    assign red       = (phase_reg == PH_TWIN) ? cfg.fog_color[23:16] : o_reg.r;
    assign green     = (phase_reg == PH_TWIN) ? cfg.fog_color[15:8]  : o_reg.g;
    assign blue      = (phase_reg == PH_TWIN) ? cfg.fog_color[7:0]   : o_reg.b;
    assign alpha     = (phase_reg == PH_TWIN) ? o_reg.fog_a : o_reg.a;
    assign is_haze   = (phase_reg == PH_TWIN);
    assign last      = !o_reg.haze || (phase_reg == PH_TWIN);
    assign w_invalid = o_reg.winv;

endmodule
